### src/qrr_pkg.sv
// Shared constants and types for the quadratic real-root solver.
// No dependencies; qrr_disc, the solver top and the testbench refer to it by scoped names.
package qrr_pkg;

   // Default coefficient width and fraction bits of the roots
   localparam int COEF_BITS  = 16;
   localparam int FRAC_BITS  = 16;

   // Fixed widths of the result fields
   localparam int DISC_WIDTH = 34;
   localparam int ROOT_WIDTH = 33;

   // Root classification reported with every result
   typedef enum logic [1:0] {
      ST_TWO_ROOTS = 2'd0,
      ST_REPEATED  = 2'd1,
      ST_NO_REAL   = 2'd2,
      ST_A_ZERO    = 2'd3
   } status_type;

endpackage

### src/qrr_disc.sv
// Discriminant stages: two registered steps (products, then b*b - 4ac and status).
// Depends on qrr_pkg for the status codes.
module qrr_disc #(
   parameter int COEF_BITS = qrr_pkg::COEF_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic signed [COEF_BITS-1:0]   in_a,
   input  logic signed [COEF_BITS-1:0]   in_b,
   input  logic signed [COEF_BITS-1:0]   in_c,
   output logic                          out_vld,
   output logic signed [COEF_BITS-1:0]   out_a,
   output logic signed [COEF_BITS-1:0]   out_b,
   output logic signed [2*COEF_BITS+1:0] out_disc,
   output qrr_pkg::status_type           out_status
);

   localparam int PW = 2 * COEF_BITS;
   localparam int DW = 2 * COEF_BITS + 2;

   logic                        p_vld_ff;
   logic signed [COEF_BITS-1:0] p_a_ff, p_b_ff;
   logic signed [PW-1:0]        p_bb_ff, p_ac_ff;
   logic signed [PW-1:0]        bb_in, ac_in;

   logic                        d_vld_ff;
   logic signed [COEF_BITS-1:0] d_a_ff, d_b_ff;
   logic signed [DW-1:0]        d_disc_ff, disc_in;
   qrr_pkg::status_type         d_status_ff, status_in;

   // Form the two products
   always_comb begin
      bb_in = in_b * in_b;
      ac_in = in_a * in_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= in_vld;
      end
      p_a_ff  <= in_a;
      p_b_ff  <= in_b;
      p_bb_ff <= bb_in;
      p_ac_ff <= ac_in;
   end

   // Combine the products and classify the roots
   always_comb begin
      disc_in = DW'(p_bb_ff) - (DW'(p_ac_ff) <<< 2);
      if (p_a_ff == '0) begin
         status_in = qrr_pkg::ST_A_ZERO;
      end else if (disc_in < 0) begin
         status_in = qrr_pkg::ST_NO_REAL;
      end else if (disc_in == '0) begin
         status_in = qrr_pkg::ST_REPEATED;
      end else begin
         status_in = qrr_pkg::ST_TWO_ROOTS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= p_vld_ff;
      end
      d_a_ff      <= p_a_ff;
      d_b_ff      <= p_b_ff;
      d_disc_ff   <= disc_in;
      d_status_ff <= status_in;
   end

   assign out_vld    = d_vld_ff;
   assign out_a      = d_a_ff;
   assign out_b      = d_b_ff;
   assign out_disc   = d_disc_ff;
   assign out_status = d_status_ff;

endmodule

### src/qrr_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Carries an opaque side vector alongside; no package dependencies.
module qrr_sqrt #(
   parameter int ROOT_BITS = 33,
   parameter int SIDE_BITS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  logic [2*ROOT_BITS-1:0] in_rad,
   input  logic [SIDE_BITS-1:0]   in_side,
   output logic                   out_vld,
   output logic [ROOT_BITS-1:0]   out_root,
   output logic                   out_exact,
   output logic [SIDE_BITS-1:0]   out_side
);

   localparam int RW = ROOT_BITS + 3;

   logic                   vld_ff  [ROOT_BITS];
   logic [2*ROOT_BITS-1:0] rad_ff  [ROOT_BITS];
   logic [RW-1:0]          rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]   root_ff [ROOT_BITS];
   logic [SIDE_BITS-1:0]   side_ff [ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic                   vld_prev;
      logic [2*ROOT_BITS-1:0] rad_prev;
      logic [RW-1:0]          rem_prev, shift_val, trial, rem_in;
      logic [ROOT_BITS-1:0]   root_prev, root_in;
      logic [SIDE_BITS-1:0]   side_prev;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // Bring down the next digit pair and try the next root bit
      always_comb begin
         shift_val = {rem_prev[RW-3:0], rad_prev[2*(ROOT_BITS-1-k)+1 -: 2]};
         trial     = RW'({root_prev, 2'b01});
         if (shift_val >= trial) begin
            rem_in  = shift_val - trial;
            root_in = {root_prev[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shift_val;
            root_in = {root_prev[ROOT_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rad_ff[k]  <= rad_prev;
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_vld   = vld_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_exact = (rem_ff[ROOT_BITS-1] == '0);
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule

### src/qrr_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Carries an opaque side vector alongside; no package dependencies.
module qrr_div #(
   parameter int NUM_BITS  = 40,
   parameter int DEN_BITS  = 18,
   parameter int SIDE_BITS = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [DEN_BITS-1:0]  in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_vld,
   output logic [NUM_BITS-1:0]  out_quo,
   output logic [SIDE_BITS-1:0] out_side
);

   logic                 vld_ff  [NUM_BITS];
   logic [NUM_BITS-1:0]  num_ff  [NUM_BITS];
   logic [DEN_BITS-1:0]  den_ff  [NUM_BITS];
   logic [DEN_BITS-1:0]  rem_ff  [NUM_BITS];
   logic [NUM_BITS-1:0]  quo_ff  [NUM_BITS];
   logic [SIDE_BITS-1:0] side_ff [NUM_BITS];

   for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
      logic                 vld_prev;
      logic [NUM_BITS-1:0]  num_prev, quo_prev, quo_in;
      logic [DEN_BITS-1:0]  den_prev, rem_prev, rem_in;
      logic [DEN_BITS:0]    shift_val;
      logic [SIDE_BITS-1:0] side_prev;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign num_prev  = in_num;
         assign den_prev  = in_den;
         assign rem_prev  = '0;
         assign quo_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign num_prev  = num_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // Shift in the next dividend bit and subtract if it fits
      always_comb begin
         shift_val = {rem_prev, num_prev[NUM_BITS-1-k]};
         if (shift_val >= {1'b0, den_prev}) begin
            rem_in = DEN_BITS'(shift_val - {1'b0, den_prev});
            quo_in = {quo_prev[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = DEN_BITS'(shift_val);
            quo_in = {quo_prev[NUM_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         num_ff[k]  <= num_prev;
         den_ff[k]  <= den_prev;
         rem_ff[k]  <= rem_in;
         quo_ff[k]  <= quo_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_vld  = vld_ff[NUM_BITS-1];
   assign out_quo  = quo_ff[NUM_BITS-1];
   assign out_side = side_ff[NUM_BITS-1];

endmodule

### src/quadratic_real_root_solver_top.sv
// Top level of the quadratic real-root solver: discriminant, square root, dividers.
// Depends on qrr_pkg, qrr_disc, qrr_sqrt and qrr_div.

// The solver takes one coefficient transaction in every clock cycle and never
// raises busy. Each transaction produces exactly one result, strobed by
// rsp_valid for a single cycle, after passing the discriminant stages, the
// bit-per-stage square root, the numerator register, the bit-per-stage dividers
// and the output register. The receiver cannot stall the result stream, so it
// must take every strobed result as it appears.
module quadratic_real_root_solver_top #(
   parameter int COEF_BITS = qrr_pkg::COEF_BITS,
   parameter int FRAC_BITS = qrr_pkg::FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COEF_BITS-1:0]            req_coef_a,
   input  logic signed [COEF_BITS-1:0]            req_coef_b,
   input  logic signed [COEF_BITS-1:0]            req_coef_c,
   output logic                                   rsp_valid,
   output logic signed [qrr_pkg::DISC_WIDTH-1:0]  rsp_discriminant,
   output logic signed [qrr_pkg::ROOT_WIDTH-1:0]  rsp_root_larger,
   output logic signed [qrr_pkg::ROOT_WIDTH-1:0]  rsp_root_smaller,
   output logic [1:0]                             rsp_root_status
);

   localparam int DW   = 2 * COEF_BITS + 2;           // discriminant width
   localparam int SQB  = COEF_BITS + 1 + FRAC_BITS;   // scaled root width
   localparam int NW   = COEF_BITS + FRAC_BITS + 6;   // numerator width
   localparam int MW   = COEF_BITS + 2;               // divisor 4|a| width
   localparam int SW0  = 2 + DW + 2 * COEF_BITS;      // side data through root
   localparam int SWD0 = 2 + 2 + DW;                  // side data, lane 0
   localparam int LAT  = 2 + SQB + 1 + NW + 1;

   // ---------------------------------------------------------------
   // Discriminant
   // ---------------------------------------------------------------
   logic                        d_vld;
   logic signed [COEF_BITS-1:0] d_a, d_b;
   logic signed [DW-1:0]        d_disc;
   qrr_pkg::status_type         d_status;
   logic [DW-1:0]               d_rad;

   assign busy = 1'b0;

   qrr_disc #(.COEF_BITS(COEF_BITS)) u_disc (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (start),
      .in_a       (req_coef_a),
      .in_b       (req_coef_b),
      .in_c       (req_coef_c),
      .out_vld    (d_vld),
      .out_a      (d_a),
      .out_b      (d_b),
      .out_disc   (d_disc),
      .out_status (d_status)
   );

   // Feed zero to the root when there are no roots to find
   assign d_rad = (d_status == qrr_pkg::ST_TWO_ROOTS || d_status == qrr_pkg::ST_REPEATED)
                  ? d_disc : '0;

   // ---------------------------------------------------------------
   // Scaled square root
   // ---------------------------------------------------------------
   logic                        s_vld, s_exact;
   logic [SQB-1:0]              s_root;
   logic [SW0-1:0]              s_side;
   logic signed [COEF_BITS-1:0] s_a, s_b;
   logic signed [DW-1:0]        s_disc;
   logic [1:0]                  s_status;

   qrr_sqrt #(.ROOT_BITS(SQB), .SIDE_BITS(SW0)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (d_vld),
      .in_rad    ({d_rad, {(2*FRAC_BITS){1'b0}}}),
      .in_side   ({d_status, d_disc, d_a, d_b}),
      .out_vld   (s_vld),
      .out_root  (s_root),
      .out_exact (s_exact),
      .out_side  (s_side)
   );

   assign s_b      = s_side[COEF_BITS-1:0];
   assign s_a      = s_side[2*COEF_BITS-1:COEF_BITS];
   assign s_disc   = s_side[2*COEF_BITS+DW-1:2*COEF_BITS];
   assign s_status = s_side[SW0-1 -: 2];

   // ---------------------------------------------------------------
   // Numerators for both roots, folded onto a positive divisor
   // ---------------------------------------------------------------
   logic signed [NW-1:0]  bs, qx, ax, dd;
   logic [COEF_BITS:0]    a_mag;
   logic                  a_neg;
   logic [NW-1:0]         num_in [2];
   logic                  inv_in [2];
   logic                  neg_in [2];

   logic                  n_vld_ff;
   logic [NW-1:0]         n_num_ff [2];
   logic                  n_inv_ff [2];
   logic                  n_neg_ff [2];
   logic [MW-1:0]         n_den_ff;
   logic signed [DW-1:0]  n_disc_ff;
   logic [1:0]            n_status_ff;

   always_comb begin
      a_neg = s_a[COEF_BITS-1];
      a_mag = a_neg ? -(COEF_BITS+1)'(s_a) : (COEF_BITS+1)'(s_a);
      bs    = -(NW'(s_b) <<< FRAC_BITS);
      qx    = $signed(NW'(s_root));
      ax    = NW'(s_a);
      dd    = $signed(NW'(a_mag)) <<< 1;
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [NW-1:0] n, t, n0, nn;
      logic                 sp_pos;

      // Round to nearest for an exact root, floor form otherwise
      always_comb begin
         n      = (l == 0) ? bs + qx : bs - qx;
         t      = bs + ax;
         sp_pos = (l == 0) ^ a_neg;
         if (a_neg) begin
            n = -n;
            t = -t;
         end
         n0 = sp_pos ? t + qx : t - qx - NW'(1);
         if (s_exact) begin
            if (n >= 0) begin
               nn        = (n <<< 1) + dd;
               neg_in[l] = 1'b0;
            end else begin
               nn        = ((-n) <<< 1) + dd;
               neg_in[l] = 1'b1;
            end
            inv_in[l] = 1'b0;
            num_in[l] = nn;
         end else begin
            nn        = n0 <<< 1;
            inv_in[l] = nn[NW-1];
            neg_in[l] = 1'b0;
            num_in[l] = nn[NW-1] ? ~nn : nn;
         end
      end

      always_ff @(posedge clock) begin
         n_num_ff[l] <= num_in[l];
         n_inv_ff[l] <= inv_in[l];
         n_neg_ff[l] <= neg_in[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
      end else begin
         n_vld_ff <= s_vld;
      end
      n_den_ff    <= MW'({a_mag, 2'b00});
      n_disc_ff   <= s_disc;
      n_status_ff <= s_status;
   end

   // ---------------------------------------------------------------
   // Dividers, one per root
   // ---------------------------------------------------------------
   logic            q_vld, q_vld_unused;
   logic [NW-1:0]   q_quo [2];
   logic [SWD0-1:0] q_side0;
   logic [1:0]      q_side1;

   qrr_div #(.NUM_BITS(NW), .DEN_BITS(MW), .SIDE_BITS(SWD0)) u_div_plus (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (n_vld_ff),
      .in_num   (n_num_ff[0]),
      .in_den   (n_den_ff),
      .in_side  ({n_inv_ff[0], n_neg_ff[0], n_status_ff, n_disc_ff}),
      .out_vld  (q_vld),
      .out_quo  (q_quo[0]),
      .out_side (q_side0)
   );

   qrr_div #(.NUM_BITS(NW), .DEN_BITS(MW), .SIDE_BITS(2)) u_div_minus (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (n_vld_ff),
      .in_num   (n_num_ff[1]),
      .in_den   (n_den_ff),
      .in_side  ({n_inv_ff[1], n_neg_ff[1]}),
      .out_vld  (q_vld_unused),
      .out_quo  (q_quo[1]),
      .out_side (q_side1)
   );

   // ---------------------------------------------------------------
   // Undo the folding, order the roots and register the result
   // ---------------------------------------------------------------
   logic signed [NW-1:0]       r_plus, r_minus, r_hi, r_lo, r_tmp;
   logic [1:0]                 f_status;
   logic signed [DW-1:0]       f_disc;
   logic                       out_vld_ff;
   logic signed [qrr_pkg::DISC_WIDTH-1:0] out_disc_ff;
   logic signed [qrr_pkg::ROOT_WIDTH-1:0] out_hi_ff, out_lo_ff;
   logic [1:0]                 out_status_ff;

   always_comb begin
      f_status = q_side0[DW+1 -: 2];
      f_disc   = q_side0[DW-1:0];
      r_tmp    = q_side0[DW+3] ? ~q_quo[0] : q_quo[0];
      r_plus   = q_side0[DW+2] ? -r_tmp : r_tmp;
      r_tmp    = q_side1[1] ? ~q_quo[1] : q_quo[1];
      r_minus  = q_side1[0] ? -r_tmp : r_tmp;
      r_hi     = (r_plus > r_minus) ? r_plus : r_minus;
      r_lo     = (r_plus > r_minus) ? r_minus : r_plus;
      if (f_status == qrr_pkg::ST_NO_REAL || f_status == qrr_pkg::ST_A_ZERO) begin
         r_hi = '0;
         r_lo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= q_vld;
      end
      out_disc_ff   <= qrr_pkg::DISC_WIDTH'(f_disc);
      out_hi_ff     <= qrr_pkg::ROOT_WIDTH'(r_hi);
      out_lo_ff     <= qrr_pkg::ROOT_WIDTH'(r_lo);
      out_status_ff <= f_status;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_discriminant = out_disc_ff;
   assign rsp_root_larger  = out_hi_ff;
   assign rsp_root_smaller = out_lo_ff;
   assign rsp_root_status  = out_status_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("transaction did not come out after the pipeline latency");

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      q_vld == q_vld_unused)
      else $error("divider lanes out of step");

   a_no_roots_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_root_status == qrr_pkg::ST_NO_REAL ||
                     rsp_root_status == qrr_pkg::ST_A_ZERO))
      |-> (rsp_root_larger == '0 && rsp_root_smaller == '0))
      else $error("roots not cleared when there are none");

   a_repeated_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_root_status == qrr_pkg::ST_REPEATED)
      |-> (rsp_root_larger == rsp_root_smaller && rsp_discriminant == '0))
      else $error("repeated root mismatch");

   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_root_larger >= rsp_root_smaller))
      else $error("roots out of order");

endmodule

### dv/tb_top.sv
// Testbench for quadratic_real_root_solver_top: random and directed coefficient sets.
// Depends on qrr_pkg and the solver RTL; predicts roots with exact integer arithmetic.
`timescale 1ns / 1ps

class root_scoreboard;
   typedef struct {
      logic signed [33:0] disc;
      logic signed [32:0] hi;
      logic signed [32:0] lo;
      qrr_pkg::status_type status;
   } root_result_type;

   root_result_type pending[$];
   int errors;

   // floor(sqrt(d) * 2^16) by digit recurrence; exact set when remainder is zero
   function automatic longint scaled_sqrt(longint unsigned d, output bit exact);
      longint unsigned r, rem;
      r = 0;
      rem = 0;
      for (int i = 31; i >= 0; i--) begin
         rem = (rem << 2) | ((d >> (2 * i)) & 3);
         if (rem >= 4 * r + 1) begin
            rem -= 4 * r + 1;
            r = 2 * r + 1;
         end else r = 2 * r;
      end
      for (int i = 0; i < qrr_pkg::FRAC_BITS; i++) begin
         rem = rem << 2;
         if (rem >= 4 * r + 1) begin
            rem -= 4 * r + 1;
            r = 2 * r + 1;
         end else r = 2 * r;
      end
      exact = (rem == 0);
      return longint'(r);
   endfunction

   function automatic longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   // rounded root (-b*2^F + sgn*sqrt(D)*2^F) / 2a, ties away from zero
   function automatic longint solve_root(longint a, longint b, int sgn, longint q, bit exact);
      longint bs, d, n, t;
      int sp;
      bs = -b * (longint'(1) << qrr_pkg::FRAC_BITS);
      d = 2 * a;
      if (exact) begin
         n = bs + (sgn > 0 ? q : -q);
         if (d < 0) begin
            n = -n;
            d = -d;
         end
         if (n >= 0) return (2 * n + d) / (2 * d);
         return -((2 * (-n) + d) / (2 * d));
      end
      t = bs + a;
      sp = sgn;
      if (d < 0) begin
         t = -t;
         d = -d;
         sp = -sp;
      end
      if (sp > 0) return div_floor(t + q, d);
      return div_floor(t - q - 1, d);
   endfunction

   // note an accepted coefficient transaction
   function void note_request(logic signed [15:0] ca, logic signed [15:0] cb,
                              logic signed [15:0] cc);
      root_result_type e;
      longint a, b, c, disc, q, rp, rm;
      bit exact;
      a = ca;
      b = cb;
      c = cc;
      disc = b * b - 4 * a * c;
      e.disc = disc[33:0];
      e.hi = '0;
      e.lo = '0;
      if (a == 0) e.status = qrr_pkg::ST_A_ZERO;
      else if (disc < 0) e.status = qrr_pkg::ST_NO_REAL;
      else begin
         q = scaled_sqrt(longint'(disc), exact);
         rp = solve_root(a, b, 1, q, exact);
         rm = solve_root(a, b, -1, q, exact);
         e.hi = 33'(rp > rm ? rp : rm);
         e.lo = 33'(rp > rm ? rm : rp);
         e.status = (disc == 0) ? qrr_pkg::ST_REPEATED : qrr_pkg::ST_TWO_ROOTS;
      end
      pending.push_back(e);
   endfunction

   // compare one strobed result against the oldest expectation
   function void check_result(logic [33:0] disc, logic [32:0] hi, logic [32:0] lo,
                              logic [1:0] status);
      root_result_type e;
      if (pending.size() == 0) begin
         $error("unexpected result: discriminant %0h", disc);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (disc !== e.disc) begin
         $error("discriminant exp %0d got %0d", e.disc, $signed(disc));
         errors++;
      end
      if (hi !== e.hi) begin
         $error("root_larger exp %0d got %0d", e.hi, $signed(hi));
         errors++;
      end
      if (lo !== e.lo) begin
         $error("root_smaller exp %0d got %0d", e.lo, $signed(lo));
         errors++;
      end
      if (status !== e.status) begin
         $error("root_status exp %0d got %0d", e.status, status);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_coef_a = '0;
   logic signed [15:0] req_coef_b = '0;
   logic signed [15:0] req_coef_c = '0;
   logic rsp_valid;
   logic signed [33:0] rsp_discriminant;
   logic signed [32:0] rsp_root_larger;
   logic signed [32:0] rsp_root_smaller;
   logic [1:0] rsp_root_status;
   root_scoreboard roots = new();
   bit no_gaps;

   always #5 clock = ~clock;

   quadratic_real_root_solver_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_coef_c(req_coef_c),
      .rsp_valid(rsp_valid), .rsp_discriminant(rsp_discriminant),
      .rsp_root_larger(rsp_root_larger), .rsp_root_smaller(rsp_root_smaller),
      .rsp_root_status(rsp_root_status)
   );

   // record accepted transactions and check strobed results
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) roots.note_request(req_coef_a, req_coef_b, req_coef_c);
         if (rsp_valid)
            roots.check_result(rsp_discriminant, rsp_root_larger, rsp_root_smaller,
                               rsp_root_status);
      end
   end

   // present one transaction, with random gaps unless no_gaps is set, and hold until accepted
   task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c);
      while (!no_gaps && $urandom_range(99) < 29) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(8)) - 4);
         3: return 16'(int'($urandom_range(256)) - 128);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] a, b, r1, r2;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: extremes, zero a, negative/zero/positive discriminant
      send_coefs(0, 0, 0);
      send_coefs(0, 5, 7);
      send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
      send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
      send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
      send_coefs(16'sh8000, 16'sh8000, 16'sh7fff);
      send_coefs(1, 0, 1);
      send_coefs(1, 2, 1);
      send_coefs(-1, 2, -1);
      send_coefs(4, 4, 1);
      send_coefs(1, 0, -1);
      send_coefs(1, -3, 2);
      send_coefs(1, 0, 0);
      send_coefs(3, 5, 0);
      send_coefs(2, 1, -1);
      send_coefs(-2, 1, 1);
      send_coefs(1, 0, -2);
      send_coefs(16'sh8000, 0, 16'sh7fff);
      send_coefs(16'sh7fff, 1, 0);
      send_coefs(-1, -1, -1);
      // random: roughly half built from chosen roots so the discriminant is not negative
      for (int i = 0; i < 600; i++) begin
         no_gaps = (i >= 250 && i < 350);
         if ($urandom_range(1)) begin
            a = 16'(int'($urandom_range(40)) - 20);
            r1 = 16'(int'($urandom_range(60)) - 30);
            r2 = ($urandom_range(3) == 0) ? r1 : 16'(int'($urandom_range(60)) - 30);
            b = -a * (r1 + r2);
            send_coefs(a, b, a * r1 * r2);
         end else send_coefs(pick_coef(), pick_coef(), pick_coef());
      end
      start <= 1'b0;
      while (roots.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (roots.errors == 0) $display("quadratic_real_root_solver_top regression: pass");
      else $display("quadratic_real_root_solver_top regression: fail");
      $finish;
   end

   initial begin
      #2ms;
      $display("quadratic_real_root_solver_top regression: fail");
      $finish;
   end
endmodule
